@@ hw/rtl/cascade_split_depths_assert.svh @@
// assertion macros for the cascade split depth block
// used by the checker only; no other dependencies
`ifndef CASCADE_SPLIT_DEPTHS_ASSERT_SVH
`define CASCADE_SPLIT_DEPTHS_ASSERT_SVH

// same-cycle implication
`define CSD_ASSERT_IMPLY(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("same-cycle check failed");

// next-cycle implication
`define CSD_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("next-cycle check failed");

`endif

@@ hw/rtl/csd_pkg.sv @@
// shared constants, payload types and the root table of the split depth block
// no dependencies
package csd_pkg;

   localparam int CASCADES_DEF = 4;
   localparam int LOG_FRAC     = 26;
   localparam int MANT_FRAC    = 30;
   localparam int LOG_W        = LOG_FRAC + 5;
   localparam int NUM_W        = 40;
   localparam int DIV_STAGES   = NUM_W / 8;
   localparam int LAM_W        = 17;
   localparam logic [LAM_W-1:0] LAMBDA_ONE   = 17'd65536;
   localparam logic [LAM_W-1:0] LAMBDA_RESET = 17'd62259;

   typedef struct packed {
      logic [31:0] near_clip;
      logic [31:0] far_clip;
   } log_side_type;

   typedef struct packed {
      logic [3:0] cascade;
      logic       last;
      logic       bad;
      logic       far_zero;
   } cas_tag_type;

   typedef struct packed {
      cas_tag_type tag;
      logic [31:0] uni;
   } pow_side_type;

   typedef logic [LOG_FRAC-1:0][30:0] roots_type;

   // roots 2^(2^-(j+1)) in Q1.30 by repeated floor square roots of 2.0
   function automatic roots_type calc_roots();
      roots_type   res_tab;
      logic [63:0] r;
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] bq;
      r = 64'd1 << 31;
      for (int j = 0; j < LOG_FRAC; j++) begin
         v   = r << MANT_FRAC;
         res = '0;
         bq  = 64'd1 << 62;
         for (int k = 0; k < 32; k++) begin
            if (bq > v) bq = bq >> 2;
         end
         for (int k = 0; k < 32; k++) begin
            if (bq != 0) begin
               if (v >= res + bq) begin
                  v   = v - (res + bq);
                  res = (res >> 1) + bq;
               end else begin
                  res = res >> 1;
               end
               bq = bq >> 2;
            end
         end
         r = res;
         res_tab[j] = res[30:0];
      end
      return res_tab;
   endfunction

   localparam roots_type ROOTS = calc_roots();

endpackage

@@ hw/rtl/csd_log2.sv @@
// two-lane pipelined fixed-point log2, one fraction bit per stage by squaring
// depends on csd_pkg
module csd_log2 import csd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [31:0]      x_a,
   input  logic [31:0]      x_b,
   input  log_side_type     in_side,
   output logic             out_valid,
   output logic [LOG_W-1:0] log_a,
   output logic [LOG_W-1:0] log_b,
   output log_side_type     out_side
);

   localparam int STAGES = LOG_FRAC + 1;

   logic [STAGES-1:0]      valid_ff;
   log_side_type           side_ff [STAGES];
   logic [1:0][31:0]       x_in;
   logic [1:0][LOG_W-1:0]  log_out;

   assign x_in = {x_b, x_a};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= in_side;
         for (int s = 1; s < STAGES; s++) side_ff[s] <= side_ff[s-1];
      end
   end

   for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [4:0]       top_in;
      logic [61:0]      norm;
      logic [30:0]      m_ff   [LOG_FRAC];
      logic [LOG_W-1:0] acc_ff [STAGES];

      // index of the top set bit
      always_comb begin
         top_in = '0;
         for (int b = 1; b < 32; b++) begin
            if (x_in[l][b]) top_in = 5'(b);
         end
      end

      // mantissa to q1.30
      assign norm = {x_in[l], 30'b0} >> top_in;

      always_ff @(posedge clock) begin
         if (en) begin
            m_ff[0]   <= norm[30:0];
            acc_ff[0] <= {top_in, {LOG_FRAC{1'b0}}};
         end
      end

      for (genvar s = 1; s <= LOG_FRAC; s++) begin : g_sq
         logic [61:0] sq;
         logic [31:0] sh;
         assign sq = 62'(m_ff[s-1]) * 62'(m_ff[s-1]);
         assign sh = sq[61:30];
         always_ff @(posedge clock) begin
            if (en) begin
               acc_ff[s] <= acc_ff[s-1]
                  | ({{(LOG_W-1){1'b0}}, sh[31]} << (LOG_FRAC - s));
            end
         end
         if (s < LOG_FRAC) begin : g_m
            always_ff @(posedge clock) begin
               if (en) m_ff[s] <= sh[31] ? sh[31:1] : sh[30:0];
            end
         end
      end

      assign log_out[l] = acc_ff[LOG_FRAC];
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_side  = side_ff[STAGES-1];
   assign log_a     = log_out[0];
   assign log_b     = log_out[1];

endmodule

@@ hw/rtl/csd_div.sv @@
// two-lane pipelined division by the cascade count, eight quotient bits a stage
// depends on csd_pkg
module csd_div import csd_pkg::*; #(
   parameter int DIVISOR = CASCADES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] num_a,
   input  logic [NUM_W-1:0] num_b,
   input  cas_tag_type      in_tag,
   output logic             out_valid,
   output logic [NUM_W-1:0] quo_a,
   output logic [NUM_W-1:0] quo_b,
   output cas_tag_type      out_tag
);

   logic [DIV_STAGES-1:0]     valid_ff;
   cas_tag_type               tag_ff [DIV_STAGES];
   logic [1:0][NUM_W-1:0]     num_in;
   logic [1:0][NUM_W-1:0]     quo_out;

   function automatic logic [12:0] div_chunk(input logic [4:0] rem_i, input logic [7:0] chunk);
      logic [5:0] r;
      logic [7:0] q;
      r = {1'b0, rem_i};
      for (int k = 7; k >= 0; k--) begin
         r = {r[4:0], chunk[k]};
         if (r >= 6'(DIVISOR)) begin
            r    = r - 6'(DIVISOR);
            q[k] = 1'b1;
         end else begin
            q[k] = 1'b0;
         end
      end
      return {r[4:0], q};
   endfunction

   assign num_in = {num_b, num_a};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[DIV_STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag_ff[0] <= in_tag;
         for (int s = 1; s < DIV_STAGES; s++) tag_ff[s] <= tag_ff[s-1];
      end
   end

   for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [NUM_W-1:0] num_ff [DIV_STAGES-1];
      logic [4:0]       rem_ff [DIV_STAGES-1];
      logic [NUM_W-1:0] q_ff   [DIV_STAGES];

      for (genvar s = 0; s < DIV_STAGES; s++) begin : g_st
         logic [NUM_W-1:0] n_src;
         logic [NUM_W-1:0] q_src;
         logic [4:0]       r_src;
         logic [12:0]      step;
         if (s == 0) begin : g_first
            assign n_src = num_in[l];
            assign q_src = '0;
            assign r_src = '0;
         end else begin : g_next
            assign n_src = num_ff[s-1];
            assign q_src = q_ff[s-1];
            assign r_src = rem_ff[s-1];
         end
         assign step = div_chunk(r_src, n_src[NUM_W-1-8*s -: 8]);
         always_ff @(posedge clock) begin
            if (en) q_ff[s] <= q_src | (NUM_W'(step[7:0]) << (NUM_W - 8 - 8*s));
         end
         if (s < DIV_STAGES - 1) begin : g_keep
            always_ff @(posedge clock) begin
               if (en) begin
                  num_ff[s] <= n_src;
                  rem_ff[s] <= step[12:8];
               end
            end
         end
      end

      assign quo_out[l] = q_ff[DIV_STAGES-1];
   end

   assign out_valid = valid_ff[DIV_STAGES-1];
   assign out_tag   = tag_ff[DIV_STAGES-1];
   assign quo_a     = quo_out[0];
   assign quo_b     = quo_out[1];

endmodule

@@ hw/rtl/csd_pow2.sv @@
// pipelined fixed-point exp2: one root product per fraction bit, then scale and round
// depends on csd_pkg
module csd_pow2 import csd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [LOG_W-1:0] e_in,
   input  pow_side_type     in_side,
   output logic             out_valid,
   output logic [31:0]      lg_out,
   output pow_side_type     out_side
);

   localparam int STAGES = LOG_FRAC + 1;

   logic [STAGES:0]   valid_ff;
   pow_side_type      side_ff [STAGES+1];
   logic [30:0]       m_ff    [STAGES];
   logic [LOG_W-1:0]  e_ff    [STAGES];
   logic [31:0]       lg_ff;
   logic [4:0]        k_sh;
   logic [62:0]       scaled;
   logic [62:0]       rounded;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[STAGES-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= in_side;
         for (int s = 1; s <= STAGES; s++) side_ff[s] <= side_ff[s-1];
         m_ff[0] <= 31'd1 << MANT_FRAC;
         e_ff[0] <= e_in;
      end
   end

   for (genvar s = 1; s <= LOG_FRAC; s++) begin : g_mul
      logic [61:0] prod;
      assign prod = 62'(m_ff[s-1]) * 62'(ROOTS[s-1]);
      always_ff @(posedge clock) begin
         if (en) begin
            m_ff[s] <= e_ff[s-1][LOG_FRAC-s] ? prod[60:30] : m_ff[s-1];
            e_ff[s] <= e_ff[s-1];
         end
      end
   end

   assign k_sh    = e_ff[LOG_FRAC][LOG_W-1:LOG_FRAC];
   assign scaled  = 63'(m_ff[LOG_FRAC]) << k_sh;
   assign rounded = scaled + (63'd1 << (MANT_FRAC - 1));

   always_ff @(posedge clock) begin
      if (en) lg_ff <= rounded[62] ? '1 : rounded[61:30];
   end

   assign out_valid = valid_ff[STAGES];
   assign out_side  = side_ff[STAGES];
   assign lg_out    = lg_ff;

endmodule

@@ hw/rtl/cascade_split_depths.sv @@
// top level of the cascade split depth block: config register, fan-out and blend
// depends on csd_pkg, csd_log2, csd_div, csd_pow2
//
// Takes one word of near and far clip depths (unsigned q16.16) and returns
// CASCADES words, one split depth per cascade in order, the final one marked
// by rsp_tlast. Each split blends a logarithmic split and a uniform split by
// the q1.16 weight blend_lambda (register 0, byte address 0; values above
// 1.0 act as 1.0). A zero near depth sets rsp_tuser and returns zero depths.
// The fan-out stage takes the next log2 result only as it issues the last
// cascade of the held one, one cascade per cycle onto the single result
// channel while rsp_tready does not stall it; behind it the pipeline takes a
// new cascade every cycle unless stalled. Path: 27 log2 stages, fan-out,
// numerator, 5 divide stages, 28 exp2 stages, blend multiply, output register.
// rsp_tready low stalls the cascade side, and log2 once full; no word is lost or repeated.
module cascade_split_depths import csd_pkg::*; #(
   parameter int CASCADES = CASCADES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // input words
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] near_clip, [63:32] far_clip
   // result words
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] split_depth, [35:32] cascade_number, rest zero
   output logic        rsp_tlast,   // last_split
   output logic        rsp_tuser,   // bad_depth
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic [3:0] LAST_CAS = 4'(CASCADES - 1);
   localparam logic [4:0] CAS_N    = 5'(CASCADES);

   // config register
   logic [LAM_W-1:0] lam_ff;
   logic [LAM_W-1:0] lam_eff;
   logic             lam_wr;

   assign csr_pready = 1'b1;
   assign lam_wr     = csr_psel & csr_penable & csr_pwrite & ~csr_paddr[2];
   assign csr_prdata = csr_paddr[2] ? 32'd0 : 32'(lam_ff);
   assign lam_eff    = (lam_ff > LAMBDA_ONE) ? LAMBDA_ONE : lam_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lam_ff <= LAMBDA_RESET;
      end else if (lam_wr) begin
         lam_ff <= csr_pwdata[LAM_W-1:0];
      end
   end

   // pipeline advance: cascade side moves unless the output word is held
   logic cas_en;
   logic log_en;
   logic exp_take;

   assign cas_en = ~rsp_tvalid | rsp_tready;

   // log2 of both depths
   logic             log_valid;
   logic [LOG_W-1:0] ln_out;
   logic [LOG_W-1:0] lf_out;
   log_side_type     log_side_in;
   log_side_type     log_side_out;

   assign log_side_in = '{near_clip: req_tdata[31:0], far_clip: req_tdata[63:32]};
   assign log_en      = ~log_valid | exp_take;
   assign req_tready  = log_en;

   csd_log2 u_log2 (
      .clock     (clock),
      .reset     (reset),
      .en        (log_en),
      .in_valid  (req_tvalid),
      .x_a       (req_tdata[31:0]),
      .x_b       (req_tdata[63:32]),
      .in_side   (log_side_in),
      .out_valid (log_valid),
      .log_a     (ln_out),
      .log_b     (lf_out),
      .out_side  (log_side_out)
   );

   // fan-out: one cascade per cycle from the held input while the cascade side moves
   logic             exp_valid_ff;
   logic [3:0]       cnt_ff;
   logic [LOG_W-1:0] ln_ff;
   logic [LOG_W-1:0] lf_ff;
   logic [31:0]      near_ff;
   logic [31:0]      far_ff;
   logic             exp_last;

   assign exp_last = (cnt_ff == LAST_CAS);
   assign exp_take = log_valid & (~exp_valid_ff | (cas_en & exp_last));

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else if (exp_take) begin
         exp_valid_ff <= 1'b1;
         cnt_ff       <= '0;
      end else if (exp_valid_ff & cas_en) begin
         if (exp_last) begin
            exp_valid_ff <= 1'b0;
         end else begin
            cnt_ff <= cnt_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (exp_take) begin
         ln_ff   <= ln_out;
         lf_ff   <= lf_out;
         near_ff <= log_side_out.near_clip;
         far_ff  <= log_side_out.far_clip;
      end
   end

   // weighted numerators for exponent and uniform split
   logic [4:0]       wa;
   logic [4:0]       wb;
   logic             mac_valid_ff;
   logic [NUM_W-1:0] e_num_ff;
   logic [NUM_W-1:0] u_num_ff;
   cas_tag_type      mac_tag_ff;

   assign wa = {1'b0, cnt_ff} + 5'd1;
   assign wb = CAS_N - wa;

   always_ff @(posedge clock) begin
      if (reset) begin
         mac_valid_ff <= 1'b0;
      end else if (cas_en) begin
         mac_valid_ff <= exp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cas_en) begin
         e_num_ff <= NUM_W'(ln_ff) * NUM_W'(wb) + NUM_W'(lf_ff) * NUM_W'(wa)
                     + NUM_W'(CAS_N >> 1);
         u_num_ff <= NUM_W'(near_ff) * NUM_W'(wb) + NUM_W'(far_ff) * NUM_W'(wa)
                     + NUM_W'(CAS_N >> 1);
         mac_tag_ff <= '{cascade: cnt_ff, last: exp_last, bad: (near_ff == 32'd0),
                         far_zero: (far_ff == 32'd0)};
      end
   end

   // divide both numerators by the cascade count
   logic             div_valid;
   logic [NUM_W-1:0] e_quo;
   logic [NUM_W-1:0] u_quo;
   cas_tag_type      div_tag;

   csd_div #(.DIVISOR(CASCADES)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (cas_en),
      .in_valid  (mac_valid_ff),
      .num_a     (e_num_ff),
      .num_b     (u_num_ff),
      .in_tag    (mac_tag_ff),
      .out_valid (div_valid),
      .quo_a     (e_quo),
      .quo_b     (u_quo),
      .out_tag   (div_tag)
   );

   // exp2 for the logarithmic split
   logic         pow_valid;
   logic [31:0]  lg;
   pow_side_type pow_side_in;
   pow_side_type pow_side_out;

   assign pow_side_in = '{tag: div_tag, uni: u_quo[31:0]};

   csd_pow2 u_pow2 (
      .clock     (clock),
      .reset     (reset),
      .en        (cas_en),
      .in_valid  (div_valid),
      .e_in      (e_quo[LOG_W-1:0]),
      .in_side   (pow_side_in),
      .out_valid (pow_valid),
      .lg_out    (lg),
      .out_side  (pow_side_out)
   );

   // blend: products first, then sum, round and saturate
   logic        bl_valid_ff;
   logic [48:0] p_log_ff;
   logic [48:0] p_uni_ff;
   cas_tag_type bl_tag_ff;
   logic [31:0] lg_eff;
   logic [49:0] blend_sum;
   logic [33:0] blend_q;

   assign lg_eff = pow_side_out.tag.far_zero ? 32'd0 : lg;

   always_ff @(posedge clock) begin
      if (reset) begin
         bl_valid_ff <= 1'b0;
      end else if (cas_en) begin
         bl_valid_ff <= pow_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (cas_en) begin
         p_log_ff  <= 49'(lam_eff) * 49'(lg_eff);
         p_uni_ff  <= 49'(LAMBDA_ONE - lam_eff) * 49'(pow_side_out.uni);
         bl_tag_ff <= pow_side_out.tag;
      end
   end

   assign blend_sum = 50'(p_log_ff) + 50'(p_uni_ff) + 50'd32768;
   assign blend_q   = blend_sum[49:16];

   // output register
   logic        rsp_valid_ff;
   logic [31:0] split_ff;
   cas_tag_type out_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cas_en) begin
         rsp_valid_ff <= bl_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cas_en) begin
         out_tag_ff <= bl_tag_ff;
         if (bl_tag_ff.bad) begin
            split_ff <= '0;
         end else begin
            split_ff <= (blend_q[33:32] != 2'b00) ? '1 : blend_q[31:0];
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, out_tag_ff.cascade, split_ff};
   assign rsp_tlast  = out_tag_ff.last;
   assign rsp_tuser  = out_tag_ff.bad;

endmodule

@@ hw/rtl/csd_check.sv @@
// port-level checker for the split depth block, bound to the top level
// depends on csd_pkg and cascade_split_depths_assert.svh
`include "cascade_split_depths_assert.svh"

module csd_check import csd_pkg::*; #(
   parameter int CASCADES = CASCADES_DEF
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        rsp_tuser
);

   localparam logic [3:0] LAST_CAS = 4'(CASCADES - 1);

   // expected cascade number of the next word
   logic [3:0] exp_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_cnt_ff <= '0;
      end else if (rsp_tvalid & rsp_tready) begin
         exp_cnt_ff <= rsp_tlast ? 4'd0 : exp_cnt_ff + 4'd1;
      end
   end

   `CSD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `CSD_ASSERT_IMPLY(a_cas_order, clock, reset, rsp_tvalid, rsp_tdata[35:32] == exp_cnt_ff)
   `CSD_ASSERT_IMPLY(a_last_mark, clock, reset, rsp_tvalid, rsp_tlast == (rsp_tdata[35:32] == LAST_CAS))
   `CSD_ASSERT_IMPLY(a_bad_zero, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata[31:0] == 32'd0)

endmodule

bind cascade_split_depths csd_check #(.CASCADES(CASCADES)) u_csd_check (.*);
